// File: sv/morse_press_decoder_macros.svh
// ----------------------------------------------------------------------------
// morse_press_decoder assertion macros
// Concurrent assertion shorthands, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef MORSE_PRESS_DECODER_MACROS_SVH
`define MORSE_PRESS_DECODER_MACROS_SVH

// antecedent implies consequent on the next edge, outside reset
`define MPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent in the same cycle, outside reset
`define MPD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds on the edge after a reset cycle
`define MPD_ASSERT_AFTER_RESET(label, cond, msg) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cond)) \
        else $error(msg);

`endif

// File: sv/mpd_pkg.sv
// ----------------------------------------------------------------------------
// mpd_pkg
// Types, constants and the symbol table of the Morse press decoder.
// ----------------------------------------------------------------------------
package mpd_pkg;

    localparam int PRESS_W   = 16;
    localparam int CODE_W    = 7;
    localparam int COUNT_W   = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] MAX_SYMBOLS = 4'd7;
    localparam logic [COUNT_W-1:0] OVER_COUNT  = 4'd8;

    localparam logic [PRESS_W-1:0] DOT_MIN_RESET = 16'd40;
    localparam logic [PRESS_W-1:0] DOT_MAX_RESET = 16'd170;

    localparam logic [CFG_IDX_W-1:0] CFG_DOT_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOT_MAX = 1'b1;

    typedef struct packed {
        logic [PRESS_W-1:0] press_ms;
        logic               end_of_char;
    } t_in;

    typedef struct packed {
        logic [CODE_W-1:0] char_code;
        logic              found;
    } t_out;

    // symbol i in bit i, dash = 1
    typedef struct packed {
        logic [6:0]         bits;
        logic [COUNT_W-1:0] count;
    } t_pattern;

    function automatic logic [CODE_W-1:0] lookup_code(input t_pattern p);
        logic [CODE_W-1:0] code;
        code = 7'h00;
        case (p.count)
            4'd1: begin
                case (p.bits[0])
                    1'b0: code = 7'h45;
                    1'b1: code = 7'h54;
                    default: code = 7'h00;
                endcase
            end
            4'd2: begin
                case (p.bits[1:0])
                    2'b10: code = 7'h41;
                    2'b00: code = 7'h49;
                    2'b11: code = 7'h4D;
                    2'b01: code = 7'h4E;
                    default: code = 7'h00;
                endcase
            end
            4'd3: begin
                case (p.bits[2:0])
                    3'b001: code = 7'h44;
                    3'b011: code = 7'h47;
                    3'b101: code = 7'h4B;
                    3'b111: code = 7'h4F;
                    3'b010: code = 7'h52;
                    3'b000: code = 7'h53;
                    3'b100: code = 7'h55;
                    3'b110: code = 7'h57;
                    default: code = 7'h00;
                endcase
            end
            4'd4: begin
                case (p.bits[3:0])
                    4'b0001: code = 7'h42;
                    4'b0101: code = 7'h43;
                    4'b0100: code = 7'h46;
                    4'b0000: code = 7'h48;
                    4'b1110: code = 7'h4A;
                    4'b0010: code = 7'h4C;
                    4'b0110: code = 7'h50;
                    4'b1011: code = 7'h51;
                    4'b1000: code = 7'h56;
                    4'b1001: code = 7'h58;
                    4'b1101: code = 7'h59;
                    4'b0011: code = 7'h5A;
                    default: code = 7'h00;
                endcase
            end
            4'd5: begin
                case (p.bits[4:0])
                    5'b11110: code = 7'h31;
                    5'b11100: code = 7'h32;
                    5'b11000: code = 7'h33;
                    5'b10000: code = 7'h34;
                    5'b00000: code = 7'h35;
                    5'b00001: code = 7'h36;
                    5'b00011: code = 7'h37;
                    5'b00111: code = 7'h38;
                    5'b01111: code = 7'h39;
                    5'b11111: code = 7'h30;
                    5'b01001: code = 7'h2F;
                    5'b01101: code = 7'h28;
                    5'b00010: code = 7'h26;
                    5'b10001: code = 7'h3D;
                    5'b01010: code = 7'h2B;
                    default:  code = 7'h00;
                endcase
            end
            4'd6: begin
                case (p.bits[5:0])
                    6'b101010: code = 7'h2E;
                    6'b110011: code = 7'h2C;
                    6'b001100: code = 7'h3F;
                    6'b011110: code = 7'h27;
                    6'b110101: code = 7'h21;
                    6'b101101: code = 7'h29;
                    6'b000111: code = 7'h3A;
                    6'b010101: code = 7'h3B;
                    6'b100001: code = 7'h2D;
                    6'b101100: code = 7'h5F;
                    6'b010010: code = 7'h22;
                    6'b010110: code = 7'h40;
                    default:   code = 7'h00;
                endcase
            end
            4'd7: begin
                case (p.bits)
                    7'b1001000: code = 7'h24;
                    default:    code = 7'h00;
                endcase
            end
            default: code = 7'h00;
        endcase
        return code;
    endfunction

endpackage

// File: sv/morse_press_decoder.sv
// ----------------------------------------------------------------------------
// morse_press_decoder
// The final press request is held in the input register, then its result in
// the result register. Throughput: one press per cycle unless the result is
// blocked; classify, accumulate and table match sit between those registers.
// Reset: synchronous, active low; clears the pattern and both valid flags, and
// sets the dot thresholds to 40 ms and 170 ms.
// ----------------------------------------------------------------------------
module morse_press_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  mpd_pkg::t_in                   i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output mpd_pkg::t_out                  o_out,
    input  logic                           i_cfg_we,
    input  logic [mpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mpd_pkg::PRESS_W-1:0]    i_cfg_data
);

    logic              r_in_valid;
    mpd_pkg::t_in      r_in;
    logic              r_out_valid;
    mpd_pkg::t_out     r_out;
    logic              proceed;
    logic              in_acc;
    mpd_pkg::t_pattern pattern;
    mpd_pkg::t_out     result;

    assign proceed    = r_in_valid && (!r_in.end_of_char || !r_out_valid || i_out_ready);
    assign o_in_ready = i_rst_n && (!r_in_valid || proceed);
    assign in_acc     = i_in_valid && o_in_ready;

    mpd_collect u_collect (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (proceed),
        .i_item     (r_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_pattern  (pattern)
    );

    mpd_lookup u_lookup (
        .i_pattern (pattern),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (proceed) begin
                r_in_valid <= 1'b0;
            end
            if (proceed && r_in.end_of_char) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in;
        end
        if (proceed && r_in.end_of_char) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: sv/mpd_collect.sv
// ----------------------------------------------------------------------------
// mpd_collect
// Threshold registers, press classification and pattern accumulation.
// ----------------------------------------------------------------------------
module mpd_collect (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  mpd_pkg::t_in                   i_item,
    input  logic                           i_cfg_we,
    input  logic [mpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mpd_pkg::PRESS_W-1:0]    i_cfg_data,
    output mpd_pkg::t_pattern              o_pattern
);

    logic [mpd_pkg::PRESS_W-1:0] r_dot_min;
    logic [mpd_pkg::PRESS_W-1:0] r_dot_max;
    logic [6:0]                  r_bits;
    logic [mpd_pkg::COUNT_W-1:0] r_count;
    logic                        r_closed;

    logic [6:0]                  upd_bits;
    logic [mpd_pkg::COUNT_W-1:0] upd_count;
    logic                        upd_closed;
    logic [6:0]                  n_bits;
    logic [mpd_pkg::COUNT_W-1:0] n_count;
    logic                        n_closed;
    logic                        is_dot;
    logic                        is_dash;

    always_comb begin
        is_dot     = (i_item.press_ms >= r_dot_min) && (i_item.press_ms <= r_dot_max);
        is_dash    = i_item.press_ms > r_dot_max;
        upd_bits   = r_bits;
        upd_count  = r_count;
        upd_closed = r_closed;
        if (!r_closed) begin
            if (is_dot || is_dash) begin
                if (r_count < mpd_pkg::MAX_SYMBOLS) begin
                    if (is_dash) begin
                        upd_bits[r_count[2:0]] = 1'b1;
                    end
                    upd_count = r_count + 4'd1;
                end else begin
                    upd_count = mpd_pkg::OVER_COUNT;
                end
            end else begin
                upd_closed = 1'b1;
            end
        end
        o_pattern.bits  = upd_bits;
        o_pattern.count = upd_count;
    end

    always_comb begin
        n_bits   = r_bits;
        n_count  = r_count;
        n_closed = r_closed;
        if (i_step) begin
            if (i_item.end_of_char) begin
                n_bits   = '0;
                n_count  = '0;
                n_closed = 1'b0;
            end else begin
                n_bits   = upd_bits;
                n_count  = upd_count;
                n_closed = upd_closed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_min <= mpd_pkg::DOT_MIN_RESET;
            r_dot_max <= mpd_pkg::DOT_MAX_RESET;
            r_bits    <= '0;
            r_count   <= '0;
            r_closed  <= 1'b0;
        end else begin
            r_bits   <= n_bits;
            r_count  <= n_count;
            r_closed <= n_closed;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mpd_pkg::CFG_DOT_MIN: r_dot_min <= i_cfg_data;
                    mpd_pkg::CFG_DOT_MAX: r_dot_max <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: sv/mpd_lookup.sv
// ----------------------------------------------------------------------------
// mpd_lookup
// Matches a finished pattern against the symbol table.
// ----------------------------------------------------------------------------
module mpd_lookup (
    input  mpd_pkg::t_pattern i_pattern,
    output mpd_pkg::t_out     o_result
);

    logic [mpd_pkg::CODE_W-1:0] code;

    always_comb begin
        code               = mpd_pkg::lookup_code(i_pattern);
        o_result.char_code = code;
        o_result.found     = code != '0;
    end

endmodule

// File: sv/mpd_checker.sv
// ----------------------------------------------------------------------------
// mpd_checker
// Port-level assertions for the Morse press decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "morse_press_decoder_macros.svh"

module mpd_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          o_in_ready,
    input  logic          o_out_valid,
    input  logic          i_out_ready,
    input  mpd_pkg::t_out o_out
);

    logic out_stall;
    logic in_busy;
    logic found_ok;

    assign out_stall = o_out_valid && !i_out_ready;
    assign in_busy   = i_in_valid && !o_in_ready;
    assign found_ok  = o_out.found == (o_out.char_code != '0);

    `MPD_ASSERT_AFTER_RESET(a_no_result_after_reset, !o_out_valid, "result valid after reset")
    `MPD_ASSERT_IMPL(a_found_code, o_out_valid, found_ok, "found and code disagree")
    `MPD_ASSERT_IMPL(a_stall_cause, !o_in_ready, out_stall, "input stalled without a blocked result")
    `MPD_ASSERT_NEXT(a_result_held, out_stall, o_out_valid && $stable(o_out), "result dropped")
    `MPD_ASSERT_IMPL(a_busy_blocked, in_busy, o_out_valid, "request refused with no result pending")

endmodule

bind morse_press_decoder mpd_checker u_mpd_checker (.*);
